// ----- rtl/msgs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers for the masked squared gradient sum core.
package msgs_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WLIM_W     = COL_W + 1;
	localparam int HLIM_W     = ROW_W + 1;
	localparam int SIZE_W     = 13;
	localparam int PIX_W      = 8;
	localparam int ADD_W      = 2 * PIX_W + 1;
	localparam int TOTAL_W    = 42;
	localparam int SUM_W      = 41;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int SIZE_RESET = 4096;

	typedef enum logic [2:0] {
		CMP_EQ = 3'd0,
		CMP_NE = 3'd1,
		CMP_GT = 3'd2,
		CMP_GE = 3'd3,
		CMP_LT = 3'd4,
		CMP_LE = 3'd5
	} cmp_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_COMPARE_VALUE = 2'd2,
		REG_COMPARE_MODE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic vld;
		logic eval;
		logic row_end;
		logic frame_end;
	} stage_ctl_t;

	function automatic logic [WLIM_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
		logic [WLIM_W-1:0] r;
		if (v == '0) begin
			r = WLIM_W'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WLIM_W'(MAX_WIDTH);
		end else begin
			r = WLIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [HLIM_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
		logic [HLIM_W-1:0] r;
		if (v == '0) begin
			r = HLIM_W'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HLIM_W'(MAX_HEIGHT);
		end else begin
			r = HLIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- rtl/msgs_line_store.sv -----
`timescale 1ns / 1ps
// Row stores: middle pixel row, row above and mask row, with registered reads.
module msgs_line_store (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [msgs_pkg::COL_W-1:0]          col,
	input  logic [msgs_pkg::COL_W-1:0]          col_next,
	input  logic [msgs_pkg::PIX_W-1:0]          pixel,
	input  logic [msgs_pkg::PIX_W-1:0]          mask_byte,
	input  logic                                above_we,
	input  logic [msgs_pkg::COL_W-1:0]          above_addr,
	input  logic [msgs_pkg::PIX_W-1:0]          above_data,
	output logic [msgs_pkg::PIX_W-1:0]          mid_q,
	output logic [msgs_pkg::PIX_W-1:0]          right_q,
	output logic [msgs_pkg::PIX_W-1:0]          above_q,
	output logic [msgs_pkg::PIX_W-1:0]          mask_q
);

	logic [msgs_pkg::PIX_W-1:0] mid_mem   [msgs_pkg::MAX_WIDTH];
	logic [msgs_pkg::PIX_W-1:0] above_mem [msgs_pkg::MAX_WIDTH];
	logic [msgs_pkg::PIX_W-1:0] mask_mem  [msgs_pkg::MAX_WIDTH];

	// middle row: one write port, two read ports (current and right column)
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_mem[col] <= pixel;
			mid_q        <= mid_mem[col];
			right_q      <= mid_mem[col_next];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mask_mem[col] <= mask_byte;
			mask_q        <= mask_mem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (above_we) begin
			above_mem[above_addr] <= above_data;
		end
		if (rd_en) begin
			above_q <= above_mem[col];
		end
	end

endmodule

// ----- rtl/msgs_grad.sv -----
`timescale 1ns / 1ps
// Mask compare, central differences and squared gradient per pixel.
module msgs_grad (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msgs_pkg::stage_ctl_t                ctl_s1,
	input  logic [msgs_pkg::PIX_W-1:0]          pixel_s1,
	input  logic [msgs_pkg::PIX_W-1:0]          above,
	input  logic [msgs_pkg::PIX_W-1:0]          right,
	input  logic [msgs_pkg::PIX_W-1:0]          left,
	input  logic [msgs_pkg::PIX_W-1:0]          mask,
	input  logic [msgs_pkg::PIX_W-1:0]          cmp_value,
	input  logic [2:0]                          cmp_mode,
	output msgs_pkg::stage_ctl_t                ctl_s2,
	output logic [msgs_pkg::ADD_W-1:0]          add_s2
);

	logic                                sel;
	logic signed [msgs_pkg::PIX_W:0]     dh;
	logic signed [msgs_pkg::PIX_W:0]     dv;
	logic signed [2*msgs_pkg::PIX_W+1:0] prod_h;
	logic signed [2*msgs_pkg::PIX_W+1:0] prod_v;
	logic [msgs_pkg::ADD_W-1:0]          add;

	always_comb begin
		case (cmp_mode)
			msgs_pkg::CMP_EQ: sel = (mask == cmp_value);
			msgs_pkg::CMP_NE: sel = (mask != cmp_value);
			msgs_pkg::CMP_GT: sel = (mask > cmp_value);
			msgs_pkg::CMP_GE: sel = (mask >= cmp_value);
			msgs_pkg::CMP_LT: sel = (mask < cmp_value);
			msgs_pkg::CMP_LE: sel = (mask <= cmp_value);
			default:          sel = 1'b0;
		endcase
	end

	always_comb begin
		dh     = $signed({1'b0, right}) - $signed({1'b0, left});
		dv     = $signed({1'b0, pixel_s1}) - $signed({1'b0, above});
		prod_h = dh * dh;
		prod_v = dv * dv;
		add    = {1'b0, prod_h[2*msgs_pkg::PIX_W-1:0]}
		       + {1'b0, prod_v[2*msgs_pkg::PIX_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		add_s2 <= (ctl_s1.eval && sel) ? add : '0;
	end

endmodule

// ----- rtl/msgs_out_fifo.sv -----
`timescale 1ns / 1ps
// Small result queue between the accumulator and the output channel.
module msgs_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [msgs_pkg::SUM_W-1:0]          push_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [msgs_pkg::SUM_W-1:0]          out_data,
	output logic [msgs_pkg::FIFO_AW:0]          count
);

	logic [msgs_pkg::SUM_W-1:0]   entries_q [msgs_pkg::FIFO_DEPTH];
	logic [msgs_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [msgs_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [msgs_pkg::FIFO_AW:0]   cnt_q;
	logic                         pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = entries_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/masked_squared_gradient_sum_core.sv -----
`timescale 1ns / 1ps
// Top level of the masked squared gradient sum core.
// Takes one pixel word per clock in raster order while input ready is high;
// each word reads the row stores once at its column (plus the right neighbor
// of the middle row) and writes them back in the same pass, so the throughput
// is one word per cycle with no clearing pass after reset. A pixel is scored
// when the pixel below it arrives; the frame total is pushed into the result
// queue from stage 2 after the frame's last word is accepted. Results wait in a
// four-entry queue; input ready drops only while that queue plus frame-ending
// words still in flight would fill it. Configuration is taken on any cycle and
// must change only while the core is idle.
module masked_squared_gradient_sum_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [msgs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [msgs_pkg::PIX_W-1:0]          pixel,
	input  logic [msgs_pkg::PIX_W-1:0]          mask_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [msgs_pkg::SUM_W-1:0]          gradient_sum
);

	logic [msgs_pkg::SIZE_W-1:0]  frame_width_q;
	logic [msgs_pkg::SIZE_W-1:0]  frame_height_q;
	logic [msgs_pkg::PIX_W-1:0]   compare_value_q;
	logic [2:0]                   compare_mode_q;

	logic [msgs_pkg::COL_W-1:0]   col_q;
	logic [msgs_pkg::ROW_W-1:0]   row_q;
	logic [msgs_pkg::WLIM_W-1:0]  w_lim;
	logic [msgs_pkg::HLIM_W-1:0]  h_lim;
	logic [msgs_pkg::WLIM_W-1:0]  col_inc;
	logic [msgs_pkg::HLIM_W-1:0]  row_inc;
	logic [msgs_pkg::COL_W-1:0]   col_next;
	logic                         accept;
	msgs_pkg::stage_ctl_t         ctl_s0;

	msgs_pkg::stage_ctl_t         ctl_s1;
	logic [msgs_pkg::PIX_W-1:0]   pixel_s1;
	logic [msgs_pkg::COL_W-1:0]   col_s1;
	logic                         fwd_s1;
	logic [msgs_pkg::PIX_W-1:0]   fwd_data_s1;
	logic [msgs_pkg::PIX_W-1:0]   left_q;

	logic [msgs_pkg::PIX_W-1:0]   mid_rd;
	logic [msgs_pkg::PIX_W-1:0]   right_rd;
	logic [msgs_pkg::PIX_W-1:0]   above_rd;
	logic [msgs_pkg::PIX_W-1:0]   mask_rd;
	logic [msgs_pkg::PIX_W-1:0]   above_val;

	msgs_pkg::stage_ctl_t         ctl_s2;
	logic [msgs_pkg::ADD_W-1:0]   add_s2;
	logic [msgs_pkg::TOTAL_W-1:0] total_q;
	logic [msgs_pkg::TOTAL_W-1:0] sum_wide;
	logic                         fifo_push;
	logic [msgs_pkg::FIFO_AW:0]   fifo_cnt;
	logic [msgs_pkg::FIFO_AW+1:0] pending;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= msgs_pkg::SIZE_W'(msgs_pkg::SIZE_RESET);
			frame_height_q  <= msgs_pkg::SIZE_W'(msgs_pkg::SIZE_RESET);
			compare_value_q <= '0;
			compare_mode_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				msgs_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data;
				msgs_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				msgs_pkg::REG_COMPARE_VALUE: compare_value_q <= cfg_data[msgs_pkg::PIX_W-1:0];
				msgs_pkg::REG_COMPARE_MODE:  compare_mode_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// stage 0: position tracking and store access
	assign pending  = (msgs_pkg::FIFO_AW+2)'(fifo_cnt)
	                + (msgs_pkg::FIFO_AW+2)'(ctl_s1.frame_end)
	                + (msgs_pkg::FIFO_AW+2)'(ctl_s2.frame_end);
	assign in_ready = (pending < (msgs_pkg::FIFO_AW+2)'(msgs_pkg::FIFO_DEPTH));
	assign accept   = in_valid && in_ready;

	always_comb begin
		w_lim            = msgs_pkg::clamp_width(frame_width_q);
		h_lim            = msgs_pkg::clamp_height(frame_height_q);
		col_inc          = {1'b0, col_q} + msgs_pkg::WLIM_W'(1);
		row_inc          = {1'b0, row_q} + msgs_pkg::HLIM_W'(1);
		col_next         = col_q + 1'b1;
		ctl_s0.vld       = 1'b1;
		ctl_s0.row_end   = (col_inc >= w_lim);
		ctl_s0.frame_end = ctl_s0.row_end && (row_inc >= h_lim);
		ctl_s0.eval      = (row_q >= msgs_pkg::ROW_W'(2)) && (col_q != '0) && (col_inc < w_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ctl_s0.row_end) begin
				col_q <= '0;
				row_q <= ctl_s0.frame_end ? '0 : row_inc[msgs_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[msgs_pkg::COL_W-1:0];
			end
		end
	end

	msgs_line_store u_store (
		.clk        (clk),
		.rd_en      (accept),
		.col        (col_q),
		.col_next   (col_next),
		.pixel      (pixel),
		.mask_byte  (mask_byte),
		.above_we   (ctl_s1.vld),
		.above_addr (col_s1),
		.above_data (mid_rd),
		.mid_q      (mid_rd),
		.right_q    (right_rd),
		.above_q    (above_rd),
		.mask_q     (mask_rd)
	);

	// stage 1: read data back; the row-above write is made from stage 1, so forward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			fwd_s1 <= 1'b0;
			left_q <= '0;
		end else begin
			ctl_s1 <= accept ? ctl_s0 : '0;
			if (accept) begin
				fwd_s1 <= ctl_s1.vld && (col_s1 == col_q);
			end
			if (ctl_s1.vld) begin
				left_q <= ctl_s1.row_end ? '0 : mid_rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel;
			col_s1      <= col_q;
			fwd_data_s1 <= mid_rd;
		end
	end

	assign above_val = fwd_s1 ? fwd_data_s1 : above_rd;

	msgs_grad u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.pixel_s1  (pixel_s1),
		.above     (above_val),
		.right     (right_rd),
		.left      (left_q),
		.mask      (mask_rd),
		.cmp_value (compare_value_q),
		.cmp_mode  (compare_mode_q),
		.ctl_s2    (ctl_s2),
		.add_s2    (add_s2)
	);

	// stage 2: accumulate, emit at frame end
	assign sum_wide  = total_q + msgs_pkg::TOTAL_W'(add_s2);
	assign fifo_push = ctl_s2.vld && ctl_s2.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl_s2.vld) begin
			total_q <= ctl_s2.frame_end ? '0 : sum_wide;
		end
	end

	msgs_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (sum_wide[msgs_pkg::SUM_W-1:0]),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (gradient_sum),
		.count     (fifo_cnt)
	);

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push && !(out_valid && out_ready)) |->
			(fifo_cnt < (msgs_pkg::FIFO_AW+1)'(msgs_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |=> out_valid)
		else $error("frame total not presented");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl_s0.eval) |-> (col_q != '0 && !ctl_s0.row_end))
		else $error("edge pixel scored");

endmodule

// ----- dv/masked_squared_gradient_sum_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the masked squared gradient sum core, with a predicting scoreboard.
module masked_squared_gradient_sum_core_tb;

	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 500;
	localparam int SETTLE     = 8;

	typedef enum int {
		FILL_RANDOM,
		FILL_EDGE,
		FILL_LEVELS
	} fill_t;

	class gradient_scoreboard;
		logic [msgs_pkg::SIZE_W-1:0]  width_reg;
		logic [msgs_pkg::SIZE_W-1:0]  height_reg;
		logic [msgs_pkg::PIX_W-1:0]   cmp_value;
		logic [2:0]                   cmp_mode;
		logic [msgs_pkg::PIX_W-1:0]   above_row [msgs_pkg::MAX_WIDTH];
		logic [msgs_pkg::PIX_W-1:0]   middle_row [msgs_pkg::MAX_WIDTH];
		logic [msgs_pkg::PIX_W-1:0]   mask_row [msgs_pkg::MAX_WIDTH];
		logic [msgs_pkg::PIX_W-1:0]   left_mid;
		int                           col;
		int                           row;
		logic [msgs_pkg::TOTAL_W-1:0] total;
		logic [msgs_pkg::SUM_W-1:0]   sums_q [$];
		int                           failures;
		int                           checked;

		function new();
			width_reg  = msgs_pkg::SIZE_W'(msgs_pkg::SIZE_RESET);
			height_reg = msgs_pkg::SIZE_W'(msgs_pkg::SIZE_RESET);
			cmp_value  = '0;
			cmp_mode   = '0;
			left_mid   = '0;
			col        = 0;
			row        = 0;
			total      = '0;
			failures   = 0;
			checked    = 0;
		endfunction

		static function int clamp_dim(logic [msgs_pkg::SIZE_W-1:0] v, int lim);
			int d;
			d = int'(v);
			if (d == 0) begin
				d = 1;
			end else if (d > lim) begin
				d = lim;
			end
			return d;
		endfunction

		function void set_reg(msgs_pkg::cfg_reg_t idx, logic [msgs_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				msgs_pkg::REG_FRAME_WIDTH:   width_reg = data;
				msgs_pkg::REG_FRAME_HEIGHT:  height_reg = data;
				msgs_pkg::REG_COMPARE_VALUE: cmp_value = data[msgs_pkg::PIX_W-1:0];
				msgs_pkg::REG_COMPARE_MODE:  cmp_mode = data[2:0];
				default: ;
			endcase
		endfunction

		function bit selects(logic [msgs_pkg::PIX_W-1:0] m);
			bit hit;
			case (cmp_mode)
				msgs_pkg::CMP_EQ: hit = (m == cmp_value);
				msgs_pkg::CMP_NE: hit = (m != cmp_value);
				msgs_pkg::CMP_GT: hit = (m > cmp_value);
				msgs_pkg::CMP_GE: hit = (m >= cmp_value);
				msgs_pkg::CMP_LT: hit = (m < cmp_value);
				msgs_pkg::CMP_LE: hit = (m <= cmp_value);
				default:          hit = 1'b0;
			endcase
			return hit;
		endfunction

		// one accepted word; scores the pixel above it
		function void note_word(logic [msgs_pkg::PIX_W-1:0] p, logic [msgs_pkg::PIX_W-1:0] m);
			int w;
			int h;
			int dh;
			int dv;
			logic [msgs_pkg::PIX_W-1:0] old_mid;
			w = clamp_dim(width_reg, msgs_pkg::MAX_WIDTH);
			h = clamp_dim(height_reg, msgs_pkg::MAX_HEIGHT);
			if (col < msgs_pkg::MAX_WIDTH) begin
				old_mid = middle_row[col];
				if (row >= 2 && col >= 1 && col + 1 < w && selects(mask_row[col])) begin
					dh = int'(middle_row[col + 1]) - int'(left_mid);
					dv = int'(p) - int'(above_row[col]);
					total = total + msgs_pkg::TOTAL_W'(dh * dh + dv * dv);
				end
				left_mid        = old_mid;
				above_row[col]  = old_mid;
				middle_row[col] = p;
				mask_row[col]   = m;
			end
			if (col + 1 >= w) begin
				col      = 0;
				left_mid = '0;
				if (row + 1 >= h) begin
					sums_q.push_back(total[msgs_pkg::SUM_W-1:0]);
					row   = 0;
					total = '0;
				end else begin
					row = row + 1;
				end
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_sum(logic [msgs_pkg::SUM_W-1:0] got);
			logic [msgs_pkg::SUM_W-1:0] want;
			if (sums_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected gradient_sum %0d with no frame pending", got);
			end else begin
				want = sums_q.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= 10)
						$display("gradient_sum mismatch, frame %0d: expected %0d, got %0d",
							checked, want, got);
				end
				checked++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [msgs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [msgs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [msgs_pkg::PIX_W-1:0]      pixel;
	logic [msgs_pkg::PIX_W-1:0]      mask_byte;
	logic                            out_valid;
	logic                            out_ready;
	logic [msgs_pkg::SUM_W-1:0]      gradient_sum;

	gradient_scoreboard sb;
	int burst_left = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int idle_cycles = 0;
	int frames_sent = 0;

	masked_squared_gradient_sum_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.mask_byte    (mask_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gradient_sum (gradient_sum)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_sum(gradient_sum);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random ready runs, plus a long hold-off when asked
	initial begin : receiver
		int run;
		int kind;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_given) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_given++;
			end
			kind = $urandom_range(0, 3);
			run  = $urandom_range(1, 24);
			repeat (run) begin
				case (kind)
					0, 1:    out_ready <= 1'b1;
					2:       out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= 1'b0;
				endcase
				@(negedge clk);
			end
		end
	end

	function automatic logic [msgs_pkg::PIX_W-1:0] pick_mask(
			input logic [msgs_pkg::PIX_W-1:0] cut);
		case ($urandom_range(0, 5))
			0:       return cut;
			1:       return cut + 8'd1;
			2:       return cut - 8'd1;
			3:       return 8'h00;
			4:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [msgs_pkg::PIX_W-1:0] p,
			input logic [msgs_pkg::PIX_W-1:0] m);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid  <= 1'b1;
		pixel     <= p;
		mask_byte <= m;
		do @(posedge clk); while (!in_ready);
		sb.note_word(p, m);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_reg(input msgs_pkg::cfg_reg_t idx,
			input logic [msgs_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic send_frame(input int fw, input int fh, input fill_t fill,
			input logic [msgs_pkg::PIX_W-1:0] cut);
		logic [msgs_pkg::PIX_W-1:0] p;
		for (int r = 0; r < fh; r++) begin
			for (int c = 0; c < fw; c++) begin
				case (fill)
					FILL_EDGE:   p = ((2 * c >= fw) ^ (2 * r >= fh)) ? 8'hff : 8'h00;
					FILL_LEVELS: p = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
						($urandom_range(0, 1) ? 8'hff : 8'h00);
					default:     p = 8'($urandom);
				endcase
				send_word(p, pick_mask(cut));
			end
		end
	endtask

	// reconfigure once idle, then stream whole frames
	task automatic run_phase(input logic [msgs_pkg::SIZE_W-1:0] w,
			input logic [msgs_pkg::SIZE_W-1:0] h,
			input logic [msgs_pkg::PIX_W-1:0] cut, input logic [2:0] mode, input int frames,
			input fill_t fill, input bit squeeze);
		in_valid <= 1'b0;
		while (sb.sums_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		write_reg(msgs_pkg::REG_FRAME_WIDTH, w);
		write_reg(msgs_pkg::REG_FRAME_HEIGHT, h);
		write_reg(msgs_pkg::REG_COMPARE_VALUE, {5'($urandom), cut});
		write_reg(msgs_pkg::REG_COMPARE_MODE, {10'($urandom), mode});
		cfg_valid <= 1'b0;
		if (squeeze)
			hold_asked++;
		repeat (frames)
			send_frame(gradient_scoreboard::clamp_dim(w, msgs_pkg::MAX_WIDTH),
				gradient_scoreboard::clamp_dim(h, msgs_pkg::MAX_HEIGHT), fill, cut);
		frames_sent += frames;
	endtask

	initial begin : stimulus
		int phase;
		int normal_words;
		int frames;
		logic [msgs_pkg::SIZE_W-1:0] w;
		logic [msgs_pkg::SIZE_W-1:0] h;
		logic [msgs_pkg::PIX_W-1:0] cut;
		logic [2:0] mode;
		fill_t fill;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = msgs_pkg::REG_FRAME_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pixel     = '0;
		mask_byte = '0;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: steepest edges, sizes that act as 1, too small, unused mode
		run_phase(13'd3, 13'd3, 8'h00, msgs_pkg::CMP_GE, 1, FILL_EDGE, 1'b0);
		run_phase(13'd0, 13'd0, 8'h00, msgs_pkg::CMP_GE, 1, FILL_EDGE, 1'b0);
		run_phase(13'd2, 13'd3, 8'h00, msgs_pkg::CMP_NE, 1, FILL_LEVELS, 1'b0);
		run_phase(13'd3, 13'd3, 8'hff, 3'd7, 1, FILL_EDGE, 1'b0);

		phase = 0;
		normal_words = 0;
		while (phase < 12 || normal_words < 900 || frames_sent < 48) begin
			case ($urandom_range(0, 3))
				0:       cut = 8'h00;
				1:       cut = 8'hff;
				default: cut = 8'($urandom);
			endcase
			mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			fill = fill_t'($urandom_range(0, 2));
			case (phase)
				3: begin
					w = 13'd5;
					h = 13'd5;
					frames = 12;
				end
				8: begin
					w = 13'd40;
					h = 13'd3;
					mode = msgs_pkg::CMP_GT;
					frames = 1;
				end
				10: begin
					w = 13'd1;
					h = 13'd40;
					frames = 1;
				end
				default: begin
					w = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2)) :
						13'($urandom_range(3, 12));
					if ($urandom_range(0, 7) == 0)
						w = 13'($urandom_range(13, 40));
					h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2)) :
						13'($urandom_range(3, 6));
					frames = $urandom_range(1, 5);
				end
			endcase
			run_phase(w, h, cut, mode, frames, fill, phase == 3);
			normal_words += frames *
				gradient_scoreboard::clamp_dim(w, msgs_pkg::MAX_WIDTH) *
				gradient_scoreboard::clamp_dim(h, msgs_pkg::MAX_HEIGHT);
			phase++;
		end

		in_valid <= 1'b0;
		while (sb.sums_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.sums_q.size() != 0)
			$display("%0d frame results never arrived", sb.sums_q.size());
		if (sb.failures == 0 && sb.sums_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
